[src/tsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants
// Opcodes, syscall numbers and result kinds of the stack CPU.
// ----------------------------------------------------------------------------
package tsc_pkg;

	localparam int DataBits = 8;
	localparam int WordBits = 16;
	localparam int KindBits = 3;
	localparam int RegIdxBits = 3;

	localparam logic [7:0] OP_NOP  = 8'h00;
	localparam logic [7:0] OP_MOV  = 8'h01;
	localparam logic [7:0] OP_ADD  = 8'h02;
	localparam logic [7:0] OP_SUB  = 8'h03;
	localparam logic [7:0] OP_CMP  = 8'h04;
	localparam logic [7:0] OP_JMP  = 8'h05;
	localparam logic [7:0] OP_JZ   = 8'h06;
	localparam logic [7:0] OP_PUSH = 8'h07;
	localparam logic [7:0] OP_POP  = 8'h08;
	localparam logic [7:0] OP_INT  = 8'h09;
	localparam logic [7:0] OP_HALT = 8'hFF;

	localparam logic [7:0] SYS_STR  = 8'h01;
	localparam logic [7:0] SYS_REG4 = 8'h02;
	localparam logic [7:0] SYS_EXIT = 8'hFF;

	typedef enum logic [KindBits-1:0] {
		K_STEP    = 3'd0,
		K_HALTED  = 3'd1,
		K_CHAR    = 3'd2,
		K_REG4    = 3'd3,
		K_EXIT    = 3'd4,
		K_BADOP   = 3'd5,
		K_BADSYS  = 3'd6,
		K_LOAD    = 3'd7
	} kind_t;

endpackage
`default_nettype wire

[src/tiny_stack_cpu_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tiny_stack_cpu_core: small 16-bit stack CPU
// Byte memory, eight registers, variable-length instructions run by a
// sequencer around one byte-wide memory port and one 16-bit adder.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                      tuser / tlast
// s_axis   in   command, address[15:0], data[7:0]       -
// m_axis   out  kind[2:0], value[15:0], pc[15:0]        tlast = last
//
// A step fetches each byte through the single memory port with a registered read;
// a push then writes two stack bytes, a pop reads two and a string walk reads its
// entries one at a time.
// The block takes no word while one is in work or a result waits in m_axis;
// a stalled m_axis also holds the string walk.
// Reset restores registers, pc, sp and flags; memory holds garbage until written.
// ----------------------------------------------------------------------------
module tiny_stack_cpu_core
	import tsc_pkg::*;
#(
	parameter int ADDR_BITS  = 16,
	parameter int NUM_REGS   = 8,
	parameter int MAX_STRING = 63
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // command, address[15:0], data[7:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // kind[2:0], value[15:0], program_counter[15:0]
	output logic             m_axis_tlast
);
	localparam int CntBits = $clog2(MAX_STRING + 1);
	localparam logic [ADDR_BITS-1:0] AOne = ADDR_BITS'(1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_FETCH = 8'b00000010,
		S_DEC   = 8'b00000100,
		S_EXEC  = 8'b00001000,
		S_STK   = 8'b00010000,
		S_STR   = 8'b00100000,
		S_STRW  = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	state_t state_q;
	logic [NUM_REGS-1:0][WordBits-1:0] rf_q;
	logic [ADDR_BITS-1:0] pc_q, sp_q, ptr_q;
	logic zf_q, nf_q, cf_q, hf_q;
	logic [7:0] op_q;
	logic [2:0] nb_q;          // instruction bytes fetched so far, opcode included
	logic [7:0] b0_q, b1_q, b2_q;
	logic [1:0] sk_q;          // stack byte phase
	logic [7:0] lo_q;
	logic [CntBits-1:0] cnt_q;
	logic out_v_q, out_l_q;
	kind_t out_k_q;
	logic [WordBits-1:0] out_val_q;

	logic ram_we;
	logic [ADDR_BITS-1:0] ram_addr;
	logic [7:0] ram_wd, ram_rd;

	tsc_ram #(.Width(DataBits), .Depth(2 ** ADDR_BITS)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wd),
		.rdata(ram_rd)
	);

	// operand count after the opcode
	function automatic logic [2:0] n_opnd(input logic [7:0] op);
		unique case (op)
			OP_MOV, OP_CMP: n_opnd = 3'd2;
			OP_ADD, OP_SUB: n_opnd = 3'd3;
			OP_JMP, OP_JZ, OP_PUSH, OP_POP, OP_INT: n_opnd = 3'd1;
			default: n_opnd = 3'd0;
		endcase
	endfunction

	// shared adder
	logic [WordBits-1:0] alu_a, alu_b;
	logic alu_sub;
	logic [WordBits:0] alu_s;
	assign alu_s = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (WordBits+1)'(alu_sub);

	logic [WordBits-1:0] ra, rb, rs;
	assign ra = rf_q[b1_q[RegIdxBits-1:0]];
	assign rb = rf_q[b2_q[RegIdxBits-1:0]];
	assign rs = rf_q[b0_q[RegIdxBits-1:0]];

	always_comb begin
		alu_sub = (op_q != OP_ADD);
		if (op_q == OP_CMP) begin
			alu_a = rf_q[b0_q[RegIdxBits-1:0]];
			alu_b = ra;
		end else begin
			alu_a = ra;
			alu_b = rb;
		end
	end

	logic [CntBits-1:0] cnt_init;
	assign cnt_init = (rf_q[1] > WordBits'(MAX_STRING)) ? CntBits'(MAX_STRING)
		: CntBits'(rf_q[1]);

	logic in_acc;
	assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// result register: free when empty or drained this cycle
	logic out_free, out_load;
	assign out_free = !out_v_q || m_axis_tready;
	assign out_load = (state_q == S_IDLE && in_acc && (!s_axis_tdata[0] || hf_q))
		|| (state_q == S_STRW && out_free && ram_rd != '0)
		|| (state_q == S_OUT && out_free);

	// memory port
	always_comb begin
		ram_we = 1'b0;
		ram_addr = pc_q;
		ram_wd = s_axis_tdata[24:17];
		unique case (state_q)
			S_IDLE: begin
				ram_we = in_acc && !s_axis_tdata[0];
				ram_addr = s_axis_tdata[ADDR_BITS:1];
			end
			S_STK: begin
				ram_addr = sp_q;
				if (op_q == OP_PUSH) begin
					ram_we = !sk_q[1];
					ram_wd = sk_q[0] ? rs[7:0] : rs[15:8];
				end else begin
					ram_addr = sp_q + AOne;
				end
			end
			// hold the string address so a stall keeps the read data
			S_STR, S_STRW: ram_addr = ptr_q;
			default: ;
		endcase
	end

	logic [ADDR_BITS-1:0] tgt;
	assign tgt = ADDR_BITS'(b0_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rf_q <= '0;
			pc_q <= '0;
			sp_q <= '1;
			{zf_q, nf_q, cf_q, hf_q} <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!s_axis_tdata[0]) begin
							out_l_q <= 1'b1;
							out_k_q <= K_LOAD; out_val_q <= '0;
						end else if (hf_q) begin
							out_l_q <= 1'b1;
							out_k_q <= K_HALTED; out_val_q <= '0;
						end else begin
							nb_q <= '0;
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					pc_q <= pc_q + AOne;
					state_q <= S_DEC;
				end
				S_DEC: begin
					// first byte read is the opcode, the rest fill operands
					if (nb_q == 3'd0) begin
						op_q <= ram_rd;
						state_q <= (n_opnd(ram_rd) == 3'd0) ? S_EXEC : S_FETCH;
					end else begin
						unique case (nb_q)
							3'd1: b0_q <= ram_rd;
							3'd2: b1_q <= ram_rd;
							default: b2_q <= ram_rd;
						endcase
						state_q <= (nb_q == n_opnd(op_q)) ? S_EXEC : S_FETCH;
					end
					nb_q <= nb_q + 3'd1;
					sk_q <= '0;
				end
				S_EXEC: begin
					out_l_q <= 1'b1; out_k_q <= K_STEP; out_val_q <= '0;
					state_q <= S_OUT;
					unique case (op_q)
						OP_NOP: ;
						OP_MOV: rf_q[b0_q[RegIdxBits-1:0]] <= WordBits'(b1_q);
						OP_ADD: begin
							rf_q[b0_q[RegIdxBits-1:0]] <= alu_s[15:0];
							zf_q <= alu_s[15:0] == '0;
							cf_q <= alu_s[16];
							nf_q <= alu_s[15];
						end
						OP_SUB, OP_CMP: begin
							if (op_q == OP_SUB) rf_q[b0_q[RegIdxBits-1:0]] <= alu_s[15:0];
							zf_q <= alu_s[15:0] == '0;
							nf_q <= !alu_s[16];
						end
						OP_JMP: pc_q <= tgt;
						OP_JZ: if (zf_q) pc_q <= tgt;
						OP_PUSH, OP_POP: state_q <= S_STK;
						OP_INT: begin
							if (b0_q == SYS_STR) begin
								cnt_q <= cnt_init;
								ptr_q <= sp_q + ADDR_BITS'({cnt_init, 1'b0}) - AOne;
								state_q <= (cnt_init == '0) ? S_OUT : S_STR;
							end else if (b0_q == SYS_REG4) begin
								out_k_q <= K_REG4; out_val_q <= rf_q[4];
							end else if (b0_q == SYS_EXIT) begin
								hf_q <= 1'b1; out_k_q <= K_EXIT;
							end else begin
								out_k_q <= K_BADSYS; out_val_q <= WordBits'(b0_q);
							end
						end
						OP_HALT: begin
							hf_q <= 1'b1; out_k_q <= K_HALTED;
						end
						default: begin
							hf_q <= 1'b1; out_k_q <= K_BADOP;
							out_val_q <= WordBits'(op_q);
						end
					endcase
				end
				S_STK: begin
					// push: write high then low; pop: read low then high
					sk_q <= sk_q + 2'd1;
					if (op_q == OP_PUSH) begin
						if (!sk_q[1]) sp_q <= sp_q - AOne;
						if (sk_q[0]) state_q <= S_OUT;
					end else begin
						if (!sk_q[1]) sp_q <= sp_q + AOne;
						if (sk_q == 2'd1) lo_q <= ram_rd;
						if (sk_q == 2'd2) begin
							rf_q[b0_q[RegIdxBits-1:0]] <= {ram_rd, lo_q};
							state_q <= S_OUT;
						end
					end
				end
				S_STR: state_q <= S_STRW;
				S_STRW: begin
					if (out_free) begin
						if (ram_rd != '0) begin
							out_l_q <= 1'b0;
							out_k_q <= K_CHAR; out_val_q <= WordBits'(ram_rd);
						end
						cnt_q <= cnt_q - CntBits'(1);
						ptr_q <= ptr_q - ADDR_BITS'(2);
						state_q <= (cnt_q == CntBits'(1)) ? S_OUT : S_STR;
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (out_k_q == K_CHAR) begin
							out_k_q <= K_STEP; out_val_q <= '0;
						end
						out_l_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast = out_l_q;
	assign m_axis_tdata = {5'd0, WordBits'(pc_q), out_val_q, out_k_q};
endmodule
`default_nettype wire

[src/tsc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_ram: generic single-port RAM
// One read or write port, registered read data.
// ----------------------------------------------------------------------------
module tsc_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

[src/tsc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_checker: port-level checks
// Watches both stream channels of the CPU core.
// ----------------------------------------------------------------------------
module tsc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [31:0] s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);
	// no new word while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
	// a load closes at once
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tdata[0] |=>
		m_axis_tvalid && m_axis_tlast && m_axis_tdata[2:0] == 3'd7)
		else $error("load result missing");
	// characters are never final and never zero
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == 3'd2 |-> !m_axis_tlast
		&& m_axis_tdata[18:3] != 16'd0) else $error("bad char word");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
endmodule

bind tiny_stack_cpu_core tsc_checker u_tsc_checker (.*);
`default_nettype wire

[tb/tiny_stack_cpu_core_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_stack_cpu_core_checker: result predictor and scoreboard
// Watches both stream channels, runs every accepted command word through a
// shadow CPU and compares each result word field by field, oldest first.
// ----------------------------------------------------------------------------
module tiny_stack_cpu_core_checker
	import tsc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // command, address[15:0], data[7:0]
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [39:0] m_axis_tdata,  // kind[2:0], value[15:0], program_counter[15:0]
	input  wire logic        m_axis_tlast,
	output int               errors,
	output int               pending
);

	localparam int StrMax = 63;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] value;
		logic [15:0] pc;
		logic        last;
	} cpu_result_t;

	cpu_result_t result_q[$];

	logic [7:0]  shadow_mem [0:65535];
	logic [15:0] shadow_regs [0:7];
	logic [15:0] shadow_pc;
	logic [15:0] shadow_sp;
	logic        flag_z;
	logic        flag_n;
	logic        flag_c;
	logic        flag_halt;

	function automatic logic [7:0] fetch_byte();
		logic [7:0] b;
		b = shadow_mem[shadow_pc];
		shadow_pc = shadow_pc + 16'd1;
		return b;
	endfunction

	function automatic void add_result(kind_t k, logic [15:0] v, logic l);
		cpu_result_t r;
		r.kind = k;
		r.value = v;
		r.pc = shadow_pc;
		r.last = l;
		result_q.push_back(r);
	endfunction

	function automatic void set_sub_flags(logic [15:0] a, logic [15:0] b);
		flag_z = (a - b) == 16'd0;
		flag_n = a < b;
	endfunction

	function automatic void execute_word(logic [31:0] w);
		logic [7:0]  op;
		logic [7:0]  num;
		logic [7:0]  ch;
		logic [2:0]  rd;
		logic [2:0]  ra;
		logic [2:0]  rb;
		logic [16:0] sum;
		logic [15:0] v;
		logic [15:0] cnt;
		int          i;
		if (!w[0]) begin
			shadow_mem[w[16:1]] = w[24:17];
			add_result(K_LOAD, 16'd0, 1'b1);
			return;
		end
		if (flag_halt) begin
			add_result(K_HALTED, 16'd0, 1'b1);
			return;
		end
		op = fetch_byte();
		case (op)
			OP_NOP: ;
			OP_MOV: begin
				rd = 3'(fetch_byte());
				shadow_regs[rd] = {8'd0, fetch_byte()};
			end
			OP_ADD: begin
				rd = 3'(fetch_byte());
				ra = 3'(fetch_byte());
				rb = 3'(fetch_byte());
				sum = {1'b0, shadow_regs[ra]} + {1'b0, shadow_regs[rb]};
				shadow_regs[rd] = sum[15:0];
				flag_z = sum[15:0] == 16'd0;
				flag_c = sum[16];
				flag_n = sum[15];
			end
			OP_SUB: begin
				rd = 3'(fetch_byte());
				ra = 3'(fetch_byte());
				rb = 3'(fetch_byte());
				v = shadow_regs[ra] - shadow_regs[rb];
				set_sub_flags(shadow_regs[ra], shadow_regs[rb]);
				shadow_regs[rd] = v;
			end
			OP_CMP: begin
				ra = 3'(fetch_byte());
				rb = 3'(fetch_byte());
				set_sub_flags(shadow_regs[ra], shadow_regs[rb]);
			end
			OP_JMP: begin
				num = fetch_byte();
				shadow_pc = {8'd0, num};
			end
			OP_JZ: begin
				num = fetch_byte();
				if (flag_z)
					shadow_pc = {8'd0, num};
			end
			OP_PUSH: begin
				rd = 3'(fetch_byte());
				v = shadow_regs[rd];
				shadow_mem[shadow_sp] = v[15:8];
				shadow_sp = shadow_sp - 16'd1;
				shadow_mem[shadow_sp] = v[7:0];
				shadow_sp = shadow_sp - 16'd1;
			end
			OP_POP: begin
				rd = 3'(fetch_byte());
				shadow_sp = shadow_sp + 16'd1;
				v[7:0] = shadow_mem[shadow_sp];
				shadow_sp = shadow_sp + 16'd1;
				v[15:8] = shadow_mem[shadow_sp];
				shadow_regs[rd] = v;
			end
			OP_INT: begin
				num = fetch_byte();
				if (num == SYS_STR) begin
					cnt = shadow_regs[1] > StrMax ? 16'(StrMax) : shadow_regs[1];
					// oldest entry sits highest in the stack
					for (i = int'(cnt); i > 0; i--) begin
						ch = shadow_mem[16'(shadow_sp + 16'd1 + 16'(2 * (i - 1)))];
						if (ch != 8'd0)
							add_result(K_CHAR, {8'd0, ch}, 1'b0);
					end
					add_result(K_STEP, 16'd0, 1'b1);
				end else if (num == SYS_REG4) begin
					add_result(K_REG4, shadow_regs[4], 1'b1);
				end else if (num == SYS_EXIT) begin
					flag_halt = 1'b1;
					add_result(K_EXIT, 16'd0, 1'b1);
				end else begin
					add_result(K_BADSYS, {8'd0, num}, 1'b1);
				end
				return;
			end
			OP_HALT: begin
				flag_halt = 1'b1;
				add_result(K_HALTED, 16'd0, 1'b1);
				return;
			end
			default: begin
				flag_halt = 1'b1;
				add_result(K_BADOP, {8'd0, op}, 1'b1);
				return;
			end
		endcase
		add_result(K_STEP, 16'd0, 1'b1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cpu_result_t exp_r;
		bit          bad;
		if (!arst_n) begin
			for (int r = 0; r < 8; r++)
				shadow_regs[r] = 16'd0;
			shadow_pc = 16'd0;
			shadow_sp = 16'hFFFF;
			flag_z = 1'b0;
			flag_n = 1'b0;
			flag_c = 1'b0;
			flag_halt = 1'b0;
			result_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (result_q.size() == 0) begin
					$error("result word with nothing expected: %h", m_axis_tdata);
					errors <= errors + 1;
				end else begin
					exp_r = result_q.pop_front();
					bad = 1'b0;
					if (m_axis_tdata[2:0] != exp_r.kind) begin
						$error("kind: expected %0d, got %0d", exp_r.kind, m_axis_tdata[2:0]);
						bad = 1'b1;
					end
					if (m_axis_tdata[18:3] != exp_r.value) begin
						$error("value: expected %h, got %h", exp_r.value, m_axis_tdata[18:3]);
						bad = 1'b1;
					end
					if (m_axis_tdata[34:19] != exp_r.pc) begin
						$error("program_counter: expected %h, got %h", exp_r.pc,
							m_axis_tdata[34:19]);
						bad = 1'b1;
					end
					if (m_axis_tlast != exp_r.last) begin
						$error("last: expected %0b, got %0b", exp_r.last, m_axis_tlast);
						bad = 1'b1;
					end
					if (bad)
						errors <= errors + 1;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				execute_word(s_axis_tdata);
			pending <= result_q.size();
		end
	end

endmodule

[tb/tiny_stack_cpu_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_stack_cpu_core_tb: stack CPU regression
// Loads short programs byte by byte just ahead of the program counter and
// steps them, with directed flag, stack and syscall cases, a deep stack run,
// random instruction mixes and one halting case at the end.
// ----------------------------------------------------------------------------
module tiny_stack_cpu_core_tb;
	import tsc_pkg::*;

	localparam int CycleLimit = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = 32'd0;  // command, address[15:0], data[7:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;  // kind[2:0], value[15:0], program_counter[15:0]
	logic        m_axis_tlast;
	int          errors;
	int          pending;
	int          cycles = 0;
	int          word_cnt = 0;
	bit          quiet = 1'b0;
	bit          written [0:65535];
	logic [15:0] gen_pc = 16'd0;
	logic [15:0] gen_sp = 16'hFFFF;

	always #6 clk = ~clk;

	tiny_stack_cpu_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	tiny_stack_cpu_core_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.errors        (errors),
		.pending       (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(input logic [31:0] w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		do @(posedge clk); while (!s_axis_tready);
		word_cnt++;
		if (word_cnt % 60 == 0)
			quiet = ~quiet;
	endtask

	task automatic load_byte(input logic [15:0] a, input logic [7:0] d);
		written[a] = 1'b1;
		send_word({7'd0, d, a, 1'b0});
	endtask

	task automatic step_cpu();
		logic [7:0]  d;
		logic [15:0] a;
		d = 8'($urandom_range(0, 255));
		a = 16'($urandom_range(0, 65535));
		send_word({7'd0, d, a, 1'b1});
	endtask

	// load the instruction at the expected pc, step it, track pc and sp
	task automatic run_instr(input logic [31:0] bytes, input int len);
		logic [7:0] op;
		op = bytes[7:0];
		for (int k = 0; k < len; k++)
			load_byte(gen_pc + 16'(k), bytes[8*k +: 8]);
		step_cpu();
		case (op)
			OP_JMP, OP_JZ: gen_pc = {8'd0, bytes[15:8]};
			default: gen_pc = gen_pc + 16'(len);
		endcase
		if (op == OP_PUSH) begin
			written[gen_sp] = 1'b1;
			written[gen_sp - 16'd1] = 1'b1;
			gen_sp = gen_sp - 16'd2;
		end else if (op == OP_POP) begin
			gen_sp = gen_sp + 16'd2;
		end
	endtask

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic do_push();
		run_instr({16'd0, rnd_byte(), OP_PUSH}, 2);
	endtask

	// pop only where both bytes above sp hold data
	task automatic do_pop();
		if (written[gen_sp + 16'd1] && written[gen_sp + 16'd2])
			run_instr({16'd0, rnd_byte(), OP_POP}, 2);
		else
			do_push();
	endtask

	// take the branch target equal to the fall-through so pc is known either way; past 255 use a jump
	task automatic do_jz();
		if (gen_pc + 16'd2 <= 16'd255)
			run_instr({16'd0, 8'(gen_pc + 16'd2), OP_JZ}, 2);
		else
			run_instr({16'd0, rnd_byte(), OP_JMP}, 2);
	endtask

	task automatic do_string(input bit saturate);
		int         safe;
		logic [7:0] n;
		safe = 0;
		while (safe < 63 && written[16'(gen_sp + 16'd1 + 16'(2 * safe))])
			safe++;
		if (saturate && safe == 63)
			n = 8'($urandom_range(64, 255));
		else
			n = 8'($urandom_range(0, safe));
		run_instr({8'd0, n, 8'd1, OP_MOV}, 3);
		run_instr({16'd0, SYS_STR, OP_INT}, 2);
	endtask

	task automatic do_syscall();
		logic [7:0] num;
		case ($urandom_range(0, 2))
			0: do_string(1'($urandom_range(0, 1)));
			1: run_instr({16'd0, SYS_REG4, OP_INT}, 2);
			default: begin
				do num = rnd_byte();
				while (num == SYS_STR || num == SYS_REG4 || num == SYS_EXIT);
				run_instr({16'd0, num, OP_INT}, 2);
			end
		endcase
	endtask

	task automatic rand_instr();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			load_byte(16'($urandom_range(0, 65535)), rnd_byte());
		else if (r < 12)
			run_instr({24'd0, OP_NOP}, 1);
		else if (r < 24)
			run_instr({8'd0, rnd_byte(), rnd_byte(), OP_MOV}, 3);
		else if (r < 34)
			run_instr({rnd_byte(), rnd_byte(), rnd_byte(), OP_ADD}, 4);
		else if (r < 44)
			run_instr({rnd_byte(), rnd_byte(), rnd_byte(), OP_SUB}, 4);
		else if (r < 50)
			run_instr({8'd0, rnd_byte(), rnd_byte(), OP_CMP}, 3);
		else if (r < 56)
			run_instr({16'd0, rnd_byte(), OP_JMP}, 2);
		else if (r < 62)
			do_jz();
		else if (r < 76)
			do_push();
		else if (r < 86)
			do_pop();
		else
			do_syscall();
	endtask

	// long receiver hold-off once while the sender keeps offering
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		forever begin
			if (!held && word_cnt > 100) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (600) @(posedge clk);
			end
			gap = pick_gap();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flags at the extremes, stack, syscalls
		run_instr({8'd0, 8'hFF, 8'd0, OP_MOV}, 3);
		run_instr({8'd0, 8'h00, 8'd7, OP_MOV}, 3);
		run_instr({8'd0, 8'd7, 8'd7, OP_SUB}, 4);
		run_instr({8'd3, 8'd3, 8'd4, OP_ADD}, 4);
		run_instr({16'd0, SYS_REG4, OP_INT}, 2);
		run_instr({8'd0, 8'd0, 8'd5, OP_SUB}, 4);
		do_jz();
		run_instr({8'd0, 8'd7, 8'd0, OP_CMP}, 3);
		run_instr({16'd0, 8'hFF, OP_JMP}, 2);
		run_instr({16'd0, 8'd3, OP_PUSH}, 2);
		run_instr({16'd0, 8'd6, OP_POP}, 2);
		run_instr({24'd0, OP_NOP}, 1);
		run_instr({16'd0, 8'h07, OP_INT}, 2);
		do_string(1'b0);

		// deep stack: a two-instruction push loop at a fixed address
		run_instr({16'd0, 8'h40, OP_JMP}, 2);
		run_instr({8'd0, 8'h81, 8'd2, OP_MOV}, 3);
		run_instr({16'd0, 8'h40, OP_JMP}, 2);
		load_byte(16'h0040, OP_PUSH);
		load_byte(16'h0041, 8'd2);
		load_byte(16'h0042, OP_JMP);
		load_byte(16'h0043, 8'h40);
		for (int k = 0; k < 64; k++) begin
			step_cpu();
			step_cpu();
			written[gen_sp] = 1'b1;
			written[gen_sp - 16'd1] = 1'b1;
			gen_sp = gen_sp - 16'd2;
		end
		gen_pc = 16'h0040;
		do_string(1'b1);

		while (word_cnt < 370)
			rand_instr();

		// one halting case, then load and step while halted
		case ($urandom_range(0, 2))
			0: run_instr({24'd0, OP_HALT}, 1);
			1: run_instr({16'd0, SYS_EXIT, OP_INT}, 2);
			default: run_instr({24'd0, 8'hA5}, 1);
		endcase
		load_byte(16'($urandom_range(0, 65535)), rnd_byte());
		step_cpu();
		step_cpu();
		s_axis_tvalid <= 1'b0;

		// let the scoreboard count the last accepted word
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
